FILE: hdl/ccr_pkg.sv
// Shared types, widths and arithmetic steps for the circle collision response block.
// Used by every module of the block; depends on nothing.
package ccr_pkg;

   localparam int SQ_STEPS = 18;
   localparam int NORM_Q   = 17;
   localparam int SCALE_Q  = 23;
   localparam logic [8:0] RESTITUTION_RESET = 9'd256;
   localparam logic [9:0] ONE_Q8 = 10'd256;

   typedef struct packed {
      logic signed [23:0] a_center_x;
      logic signed [23:0] a_center_y;
      logic signed [23:0] b_center_x;
      logic signed [23:0] b_center_y;
      logic        [15:0] a_radius;
      logic        [15:0] b_radius;
      logic signed [19:0] a_vel_x;
      logic signed [19:0] a_vel_y;
      logic signed [19:0] b_vel_x;
      logic signed [19:0] b_vel_y;
      logic        [15:0] a_mass;
      logic        [15:0] b_mass;
   } req_type;

   typedef struct packed {
      logic               hit;
      logic signed [19:0] vel_delta_x;
      logic signed [19:0] vel_delta_y;
      logic signed [23:0] pos_delta_x;
      logic signed [23:0] pos_delta_y;
   } rsp_type;

   typedef struct packed {
      logic               act;
      logic               hit;
      logic signed [17:0] dx;
      logic signed [17:0] dy;
      logic        [16:0] rsum;
      logic signed [20:0] dvx;
      logic signed [20:0] dvy;
      logic        [15:0] ma;
      logic        [15:0] mb;
   } geom_type;

   typedef struct packed {
      logic               act;
      logic               hit;
      logic signed [17:0] nx;
      logic signed [17:0] ny;
      logic        [17:0] ov;
      logic signed [20:0] dvx;
      logic signed [20:0] dvy;
      logic        [15:0] ma;
      logic        [15:0] mb;
   } norm_type;

   typedef struct packed {
      logic               act;
      logic               hit;
      logic signed [17:0] nx;
      logic signed [17:0] ny;
      logic signed [17:0] pdx;
      logic signed [17:0] pdy;
      logic signed [23:0] s;
   } scale_type;

   typedef struct packed {
      logic [35:0] rad;
      logic [35:0] root;
   } sqrt_work_type;

   typedef struct packed {
      logic [17:0] rem;
      logic        q;
   } div_res_type;

   function automatic logic [35:0] sqrt_bit(int k);
      return 36'd1 << (2 * (SQ_STEPS - 1 - k));
   endfunction

   function automatic sqrt_work_type sqrt_step(sqrt_work_type w, logic [35:0] bitv);
      sqrt_work_type res;
      logic [35:0]   trial;
      trial = w.root + bitv;
      res   = w;
      if (w.rad >= trial) begin
         res.rad  = w.rad - trial;
         res.root = (w.root >> 1) + bitv;
      end else begin
         res.root = w.root >> 1;
      end
      return res;
   endfunction

   function automatic div_res_type div_step(logic [17:0] rem, logic [17:0] dvsr, logic inb);
      div_res_type res;
      logic [18:0] trial;
      trial = {rem, inb};
      if (trial >= {1'b0, dvsr}) begin
         res.rem = 18'(trial - {1'b0, dvsr});
         res.q   = 1'b1;
      end else begin
         res.rem = trial[17:0];
         res.q   = 1'b0;
      end
      return res;
   endfunction

endpackage

FILE: hdl/ccr_if.sv
// Valid/ready channel interfaces for the request and response sides.
// Depends on nothing; the fields follow the block's payload.
interface ccr_req_if;
   logic               valid;
   logic               ready;
   logic signed [23:0] a_center_x;
   logic signed [23:0] a_center_y;
   logic signed [23:0] b_center_x;
   logic signed [23:0] b_center_y;
   logic        [15:0] a_radius;
   logic        [15:0] b_radius;
   logic signed [19:0] a_vel_x;
   logic signed [19:0] a_vel_y;
   logic signed [19:0] b_vel_x;
   logic signed [19:0] b_vel_y;
   logic        [15:0] a_mass;
   logic        [15:0] b_mass;

   modport source (output valid, a_center_x, a_center_y, b_center_x, b_center_y, a_radius,
                   b_radius, a_vel_x, a_vel_y, b_vel_x, b_vel_y, a_mass, b_mass,
                   input ready);
   modport sink (input valid, a_center_x, a_center_y, b_center_x, b_center_y, a_radius,
                 b_radius, a_vel_x, a_vel_y, b_vel_x, b_vel_y, a_mass, b_mass,
                 output ready);
endinterface

interface ccr_rsp_if;
   logic               valid;
   logic               ready;
   logic               hit;
   logic signed [19:0] vel_delta_x;
   logic signed [19:0] vel_delta_y;
   logic signed [23:0] pos_delta_x;
   logic signed [23:0] pos_delta_y;

   modport source (output valid, hit, vel_delta_x, vel_delta_y, pos_delta_x, pos_delta_y,
                   input ready);
   modport sink (input valid, hit, vel_delta_x, vel_delta_y, pos_delta_x, pos_delta_y,
                 output ready);
endinterface

FILE: hdl/ccr_front.sv
// Front stages: centre and velocity differences, squares and the contact test.
// Depends on ccr_pkg.
module ccr_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  ccr_pkg::req_type  in_req,
   output logic              out_valid,
   output ccr_pkg::geom_type out_geom,
   output logic [35:0]       out_rad
);

   logic               va_ff;
   logic signed [24:0] dxa_in, dxa_ff, dya_in, dya_ff;
   logic        [16:0] rsuma_in, rsuma_ff;
   logic signed [20:0] dvxa_in, dvxa_ff, dvya_in, dvya_ff;
   logic        [15:0] maa_in, maa_ff, mba_in, mba_ff;

   logic               vb_ff;
   logic signed [49:0] sqx_full, sqy_full;
   logic        [48:0] sqxb_ff, sqyb_ff;
   logic        [33:0] rsqb_in, rsqb_ff;
   ccr_pkg::geom_type  gb_in, gb_ff;

   logic               vc_ff;
   logic        [49:0] dist2;
   ccr_pkg::geom_type  gc_in, gc_ff;
   logic        [35:0] radc_ff;

   always_comb begin
      dxa_in   = {in_req.b_center_x[23], in_req.b_center_x}
               - {in_req.a_center_x[23], in_req.a_center_x};
      dya_in   = {in_req.b_center_y[23], in_req.b_center_y}
               - {in_req.a_center_y[23], in_req.a_center_y};
      rsuma_in = {1'b0, in_req.a_radius} + {1'b0, in_req.b_radius};
      dvxa_in  = {in_req.b_vel_x[19], in_req.b_vel_x} - {in_req.a_vel_x[19], in_req.a_vel_x};
      dvya_in  = {in_req.b_vel_y[19], in_req.b_vel_y} - {in_req.a_vel_y[19], in_req.a_vel_y};
      maa_in   = (in_req.a_mass == 16'd0) ? 16'd1 : in_req.a_mass;
      mba_in   = (in_req.b_mass == 16'd0) ? 16'd1 : in_req.b_mass;
   end

   assign sqx_full = dxa_ff * dxa_ff;
   assign sqy_full = dya_ff * dya_ff;
   assign rsqb_in  = rsuma_ff * rsuma_ff;

   always_comb begin
      gb_in      = '0;
      gb_in.dx   = dxa_ff[17:0];
      gb_in.dy   = dya_ff[17:0];
      gb_in.rsum = rsuma_ff;
      gb_in.dvx  = dvxa_ff;
      gb_in.dvy  = dvya_ff;
      gb_in.ma   = maa_ff;
      gb_in.mb   = mba_ff;
   end

   always_comb begin
      dist2     = {1'b0, sqxb_ff} + {1'b0, sqyb_ff};
      gc_in     = gb_ff;
      gc_in.hit = (dist2 <= {16'd0, rsqb_ff});
      gc_in.act = gc_in.hit && (dist2 != 50'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
      end else if (en) begin
         va_ff <= in_valid;
         vb_ff <= va_ff;
         vc_ff <= vb_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dxa_ff   <= dxa_in;
         dya_ff   <= dya_in;
         rsuma_ff <= rsuma_in;
         dvxa_ff  <= dvxa_in;
         dvya_ff  <= dvya_in;
         maa_ff   <= maa_in;
         mba_ff   <= mba_in;
         sqxb_ff  <= sqx_full[48:0];
         sqyb_ff  <= sqy_full[48:0];
         rsqb_ff  <= rsqb_in;
         gb_ff    <= gb_in;
         gc_ff    <= gc_in;
         radc_ff  <= dist2[35:0];
      end
   end

   assign out_valid = vc_ff;
   assign out_geom  = gc_ff;
   assign out_rad   = radc_ff;

endmodule

FILE: hdl/ccr_sqrt.sv
// Pipelined integer square root of the squared centre distance, one result bit per stage.
// Depends on ccr_pkg.
module ccr_sqrt (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  ccr_pkg::geom_type in_geom,
   input  logic [35:0]       in_rad,
   output logic              out_valid,
   output ccr_pkg::geom_type out_geom,
   output logic [17:0]       out_dist
);

   localparam int N = ccr_pkg::SQ_STEPS;

   ccr_pkg::sqrt_work_type w_in [N];
   ccr_pkg::sqrt_work_type w_ff [N];
   ccr_pkg::geom_type      g_in [N];
   ccr_pkg::geom_type      g_ff [N];
   logic [N-1:0]           v_in, v_ff;
   ccr_pkg::sqrt_work_type first;

   always_comb begin
      first      = '0;
      first.rad  = in_rad;
   end

   for (genvar k = 0; k < N; k++) begin : g_step
      ccr_pkg::sqrt_work_type prev;
      if (k == 0) begin : g_src
         assign prev    = first;
         assign v_in[k] = in_valid;
         assign g_in[k] = in_geom;
      end else begin : g_src
         assign prev    = w_ff[k-1];
         assign v_in[k] = v_ff[k-1];
         assign g_in[k] = g_ff[k-1];
      end
      assign w_in[k] = ccr_pkg::sqrt_step(prev, ccr_pkg::sqrt_bit(k));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         w_ff <= w_in;
         g_ff <= g_in;
      end
   end

   assign out_valid = v_ff[N-1];
   assign out_geom  = g_ff[N-1];
   assign out_dist  = w_ff[N-1].root[17:0];

   a_dist_within_rsum: assert property (@(posedge clock) disable iff (reset)
      out_valid && out_geom.act |-> out_dist <= {1'b0, out_geom.rsum})
      else $error("square root exceeds the radius sum on a contact");

endmodule

FILE: hdl/ccr_norm.sv
// Unit normal: both components of the centre difference scaled by 65536 over the distance,
// by two restoring dividers that settle one quotient bit per stage. Depends on ccr_pkg.
module ccr_norm (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  ccr_pkg::geom_type in_geom,
   input  logic [17:0]       in_dist,
   output logic              out_valid,
   output ccr_pkg::norm_type out_norm
);

   localparam int N = ccr_pkg::NORM_Q;

   typedef struct packed {
      logic [17:0] dvsr;
      logic [17:0] rem_x;
      logic [17:0] rem_y;
      logic [16:0] q_x;
      logic [16:0] q_y;
      logic        neg_x;
      logic        neg_y;
   } nwork_type;

   logic [17:0]       mag_x, mag_y;
   nwork_type         entry;
   ccr_pkg::norm_type side_entry;
   nwork_type         work_in [N];
   nwork_type         work_ff [N];
   ccr_pkg::norm_type side_in [N];
   ccr_pkg::norm_type side_ff [N];
   logic [N-1:0]      v_in, v_ff;

   always_comb begin
      mag_x       = in_geom.dx[17] ? (~in_geom.dx + 18'd1) : in_geom.dx;
      mag_y       = in_geom.dy[17] ? (~in_geom.dy + 18'd1) : in_geom.dy;
      entry       = '0;
      entry.dvsr  = in_dist;
      entry.rem_x = {2'b00, mag_x[16:1]};
      entry.rem_y = {2'b00, mag_y[16:1]};
      entry.neg_x = in_geom.dx[17];
      entry.neg_y = in_geom.dy[17];
      side_entry      = '0;
      side_entry.act  = in_geom.act;
      side_entry.hit  = in_geom.hit;
      side_entry.ov   = {1'b0, in_geom.rsum} - in_dist;
      side_entry.dvx  = in_geom.dvx;
      side_entry.dvy  = in_geom.dvy;
      side_entry.ma   = in_geom.ma;
      side_entry.mb   = in_geom.mb;
   end

   for (genvar k = 0; k < N; k++) begin : g_step
      nwork_type            prev, nxt;
      logic                 inb_x, inb_y;
      ccr_pkg::div_res_type rx, ry;
      if (k == 0) begin : g_src
         assign prev       = entry;
         assign inb_x      = mag_x[0];
         assign inb_y      = mag_y[0];
         assign v_in[k]    = in_valid;
         assign side_in[k] = side_entry;
      end else begin : g_src
         assign prev       = work_ff[k-1];
         assign inb_x      = 1'b0;
         assign inb_y      = 1'b0;
         assign v_in[k]    = v_ff[k-1];
         assign side_in[k] = side_ff[k-1];
      end
      always_comb begin
         rx        = ccr_pkg::div_step(prev.rem_x, prev.dvsr, inb_x);
         ry        = ccr_pkg::div_step(prev.rem_y, prev.dvsr, inb_y);
         nxt       = prev;
         nxt.rem_x = rx.rem;
         nxt.rem_y = ry.rem;
         nxt.q_x   = {prev.q_x[15:0], rx.q};
         nxt.q_y   = {prev.q_y[15:0], ry.q};
      end
      assign work_in[k] = nxt;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         work_ff <= work_in;
         side_ff <= side_in;
      end
   end

   always_comb begin
      out_norm    = side_ff[N-1];
      out_norm.nx = work_ff[N-1].neg_x ? -$signed({1'b0, work_ff[N-1].q_x})
                                       : $signed({1'b0, work_ff[N-1].q_x});
      out_norm.ny = work_ff[N-1].neg_y ? -$signed({1'b0, work_ff[N-1].q_y})
                                       : $signed({1'b0, work_ff[N-1].q_y});
   end

   assign out_valid = v_ff[N-1];

   a_normal_bounded: assert property (@(posedge clock) disable iff (reset)
      out_valid && out_norm.act |->
         out_norm.nx <= 18'sd65536 && out_norm.nx >= -18'sd65536 &&
         out_norm.ny <= 18'sd65536 && out_norm.ny >= -18'sd65536)
      else $error("normal component exceeds unit length");

endmodule

FILE: hdl/ccr_impulse.sv
// Impulse scale: normal relative velocity, restitution and mass products, then a pipelined
// divider by the mass sum. Also forms the position correction. Depends on ccr_pkg.
module ccr_impulse (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic [8:0]         restitution,
   input  logic               in_valid,
   input  ccr_pkg::norm_type  in_norm,
   output logic               out_valid,
   output ccr_pkg::scale_type out_scale
);

   localparam int N = ccr_pkg::SCALE_Q;

   typedef struct packed {
      logic        [17:0] dvsr;
      logic        [17:0] rem;
      logic        [22:0] low;
      logic        [22:0] q;
      logic               neg;
   } swork_type;

   // First stage: products along the normal.
   logic               v1_ff;
   ccr_pkg::scale_type side1_in, side1_ff;
   logic signed [38:0] pvx_in, pvx_ff, pvy_in, pvy_ff;
   logic signed [36:0] pox_in, pox_ff, poy_in, poy_ff;
   logic        [9:0]  coef_in, coef1_ff;
   logic        [15:0] mb1_ff;
   logic        [16:0] msum_in, msum1_ff;

   // Second stage: truncated normal velocity and position correction.
   logic               v2_ff;
   ccr_pkg::scale_type side2_in, side2_ff;
   logic signed [39:0] vsum, vadj;
   logic signed [36:0] padx, pady;
   logic signed [23:0] vn_in, vn_ff;
   logic        [9:0]  coef2_ff;
   logic        [15:0] mb2_ff;
   logic        [16:0] msum2_ff;

   // Third and fourth stages: restitution and mass products.
   logic               v3_ff, v4_ff, v5_ff;
   ccr_pkg::scale_type side3_ff, side4_ff, side5_ff;
   logic signed [34:0] t_in, t_ff;
   logic        [15:0] mb3_ff;
   logic        [16:0] msum3_ff, msum4_ff, msum5_ff;
   logic signed [51:0] u_in, u_ff;

   // Fifth stage: magnitude over 256.
   logic        [51:0] umag;
   logic        [38:0] m8_ff;
   logic               neg5_ff;

   swork_type          entry;
   swork_type          work_in [N];
   swork_type          work_ff [N];
   ccr_pkg::scale_type side_in [N];
   ccr_pkg::scale_type side_ff [N];
   logic [N-1:0]       v_in, v_ff;

   always_comb begin
      pvx_in  = in_norm.dvx * in_norm.nx;
      pvy_in  = in_norm.dvy * in_norm.ny;
      pox_in  = in_norm.nx * $signed({1'b0, in_norm.ov});
      poy_in  = in_norm.ny * $signed({1'b0, in_norm.ov});
      coef_in = ccr_pkg::ONE_Q8 + {1'b0, restitution};
      msum_in = {1'b0, in_norm.ma} + {1'b0, in_norm.mb};
      side1_in     = '0;
      side1_in.act = in_norm.act;
      side1_in.hit = in_norm.hit;
      side1_in.nx  = in_norm.nx;
      side1_in.ny  = in_norm.ny;
   end

   always_comb begin
      vsum  = 40'(pvx_ff) + 40'(pvy_ff);
      vadj  = vsum + (vsum[39] ? 40'sd65535 : 40'sd0);
      vn_in = $signed(vadj[39:16]);
      padx  = pox_ff + (pox_ff[36] ? 37'sd131071 : 37'sd0);
      pady  = poy_ff + (poy_ff[36] ? 37'sd131071 : 37'sd0);
      side2_in     = side1_ff;
      side2_in.pdx = 18'(-$signed(padx[36:17]));
      side2_in.pdy = 18'(-$signed(pady[36:17]));
   end

   assign t_in = vn_ff * $signed({1'b0, coef2_ff});
   assign u_in = t_ff * $signed({1'b0, mb3_ff});
   assign umag = u_ff[51] ? (~u_ff + 52'd1) : u_ff;

   always_comb begin
      entry      = '0;
      entry.dvsr = {1'b0, msum5_ff};
      entry.rem  = {2'b00, m8_ff[38:23]};
      entry.low  = m8_ff[22:0];
      entry.neg  = neg5_ff;
   end

   for (genvar k = 0; k < N; k++) begin : g_step
      swork_type            prev, nxt;
      ccr_pkg::div_res_type r;
      if (k == 0) begin : g_src
         assign prev       = entry;
         assign v_in[k]    = v5_ff;
         assign side_in[k] = side5_ff;
      end else begin : g_src
         assign prev       = work_ff[k-1];
         assign v_in[k]    = v_ff[k-1];
         assign side_in[k] = side_ff[k-1];
      end
      always_comb begin
         r       = ccr_pkg::div_step(prev.rem, prev.dvsr, prev.low[22]);
         nxt     = prev;
         nxt.rem = r.rem;
         nxt.low = {prev.low[21:0], 1'b0};
         nxt.q   = {prev.q[21:0], r.q};
      end
      assign work_in[k] = nxt;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v_ff  <= '0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v_ff  <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side1_ff <= side1_in;
         pvx_ff   <= pvx_in;
         pvy_ff   <= pvy_in;
         pox_ff   <= pox_in;
         poy_ff   <= poy_in;
         coef1_ff <= coef_in;
         mb1_ff   <= in_norm.mb;
         msum1_ff <= msum_in;
         side2_ff <= side2_in;
         vn_ff    <= vn_in;
         coef2_ff <= coef1_ff;
         mb2_ff   <= mb1_ff;
         msum2_ff <= msum1_ff;
         side3_ff <= side2_ff;
         t_ff     <= t_in;
         mb3_ff   <= mb2_ff;
         msum3_ff <= msum2_ff;
         side4_ff <= side3_ff;
         u_ff     <= u_in;
         msum4_ff <= msum3_ff;
         side5_ff <= side4_ff;
         m8_ff    <= umag[46:8];
         neg5_ff  <= u_ff[51];
         msum5_ff <= msum4_ff;
         work_ff  <= work_in;
         side_ff  <= side_in;
      end
   end

   always_comb begin
      out_scale   = side_ff[N-1];
      out_scale.s = work_ff[N-1].neg ? -$signed({1'b0, work_ff[N-1].q})
                                     : $signed({1'b0, work_ff[N-1].q});
   end

   assign out_valid = v_ff[N-1];

endmodule

FILE: hdl/ccr_apply.sv
// Final stages: velocity change along the normal, saturation and the result register.
// Depends on ccr_pkg.
module ccr_apply (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  ccr_pkg::scale_type in_scale,
   output logic               out_valid,
   output ccr_pkg::rsp_type   out_rsp
);

   logic               v1_ff, v2_ff;
   ccr_pkg::scale_type side1_ff;
   logic signed [41:0] vx_in, vx_ff, vy_in, vy_ff;
   logic signed [41:0] adj_x, adj_y;
   logic signed [25:0] qx, qy;
   logic signed [19:0] satx, saty;
   ccr_pkg::rsp_type   rsp_in, rsp_ff;

   assign vx_in = in_scale.s * in_scale.nx;
   assign vy_in = in_scale.s * in_scale.ny;

   always_comb begin
      adj_x = vx_ff + (vx_ff[41] ? 42'sd65535 : 42'sd0);
      adj_y = vy_ff + (vy_ff[41] ? 42'sd65535 : 42'sd0);
      qx    = $signed(adj_x[41:16]);
      qy    = $signed(adj_y[41:16]);
      if (qx > 26'sd524287) begin
         satx = 20'sd524287;
      end else if (qx < -26'sd524288) begin
         satx = -20'sd524288;
      end else begin
         satx = qx[19:0];
      end
      if (qy > 26'sd524287) begin
         saty = 20'sd524287;
      end else if (qy < -26'sd524288) begin
         saty = -20'sd524288;
      end else begin
         saty = qy[19:0];
      end
      rsp_in     = '0;
      rsp_in.hit = side1_ff.hit;
      if (side1_ff.act) begin
         rsp_in.vel_delta_x = satx;
         rsp_in.vel_delta_y = saty;
         rsp_in.pos_delta_x = 24'(side1_ff.pdx);
         rsp_in.pos_delta_y = 24'(side1_ff.pdy);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side1_ff <= in_scale;
         vx_ff    <= vx_in;
         vy_ff    <= vy_in;
         rsp_ff   <= rsp_in;
      end
   end

   assign out_valid = v2_ff;
   assign out_rsp   = rsp_ff;

endmodule

FILE: hdl/circle_collision_response.sv
// Top level of the circle collision response pipeline and its restitution register.
// Depends on ccr_pkg, ccr_if and the ccr_front, ccr_sqrt, ccr_norm, ccr_impulse, ccr_apply stages.
//
// Channel    Direction  Handshake     Carries
// req_bus    in         valid/ready   both circles: centres, radii, velocities, masses
// rsp_bus    out        valid/ready   hit flag, velocity and position change of circle A
// csr_*      in         write enable  restitution, unsigned Q1.8
//
// One request transfer is taken per cycle while the pipeline is not held.
// The depth of the pipeline comes mostly from the 18-stage square root and the 17- and 23-stage dividers.
// Reset clears every valid bit and sets restitution to 1.0.
// While a result waits on rsp_bus without ready, the whole pipeline holds its contents.
module circle_collision_response (
   input  logic         clock,
   input  logic         reset,
   ccr_req_if.sink      req_bus,
   ccr_rsp_if.source    rsp_bus,
   input  logic         csr_wr_en,
   input  logic [8:0]   csr_wr_data
);

   logic               en;
   logic [8:0]         restitution_ff;
   ccr_pkg::req_type   req;

   logic               front_valid, sqrt_valid, norm_valid, imp_valid, out_valid;
   ccr_pkg::geom_type  front_geom, sqrt_geom;
   logic [35:0]        front_rad;
   logic [17:0]        sqrt_dist;
   ccr_pkg::norm_type  norm_data;
   ccr_pkg::scale_type imp_scale;
   ccr_pkg::rsp_type   out_rsp;

   assign en            = ~out_valid | rsp_bus.ready;
   assign req_bus.ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         restitution_ff <= ccr_pkg::RESTITUTION_RESET;
      end else if (csr_wr_en) begin
         restitution_ff <= csr_wr_data;
      end
   end

   always_comb begin
      req.a_center_x = req_bus.a_center_x;
      req.a_center_y = req_bus.a_center_y;
      req.b_center_x = req_bus.b_center_x;
      req.b_center_y = req_bus.b_center_y;
      req.a_radius   = req_bus.a_radius;
      req.b_radius   = req_bus.b_radius;
      req.a_vel_x    = req_bus.a_vel_x;
      req.a_vel_y    = req_bus.a_vel_y;
      req.b_vel_x    = req_bus.b_vel_x;
      req.b_vel_y    = req_bus.b_vel_y;
      req.a_mass     = req_bus.a_mass;
      req.b_mass     = req_bus.b_mass;
   end

   ccr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_bus.valid),
      .in_req    (req),
      .out_valid (front_valid),
      .out_geom  (front_geom),
      .out_rad   (front_rad)
   );

   ccr_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (front_valid),
      .in_geom   (front_geom),
      .in_rad    (front_rad),
      .out_valid (sqrt_valid),
      .out_geom  (sqrt_geom),
      .out_dist  (sqrt_dist)
   );

   ccr_norm u_norm (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sqrt_valid),
      .in_geom   (sqrt_geom),
      .in_dist   (sqrt_dist),
      .out_valid (norm_valid),
      .out_norm  (norm_data)
   );

   ccr_impulse u_impulse (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .restitution (restitution_ff),
      .in_valid    (norm_valid),
      .in_norm     (norm_data),
      .out_valid   (imp_valid),
      .out_scale   (imp_scale)
   );

   ccr_apply u_apply (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (imp_valid),
      .in_scale  (imp_scale),
      .out_valid (out_valid),
      .out_rsp   (out_rsp)
   );

   assign rsp_bus.valid       = out_valid;
   assign rsp_bus.hit         = out_rsp.hit;
   assign rsp_bus.vel_delta_x = out_rsp.vel_delta_x;
   assign rsp_bus.vel_delta_y = out_rsp.vel_delta_y;
   assign rsp_bus.pos_delta_x = out_rsp.pos_delta_x;
   assign rsp_bus.pos_delta_y = out_rsp.pos_delta_y;

   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_bus.valid)
      else $error("result valid straight after reset");

   a_miss_gives_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && !rsp_bus.hit |->
         rsp_bus.vel_delta_x == 20'sd0 && rsp_bus.vel_delta_y == 20'sd0 &&
         rsp_bus.pos_delta_x == 24'sd0 && rsp_bus.pos_delta_y == 24'sd0)
      else $error("non-zero correction on a pair without contact");

endmodule
